>>> design/lms_pkg.sv
// lms_pkg: shared types, codes and constants of the led mode sequencer
// no dependencies; used by the channel interfaces and every design module
package lms_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned RAMP_W  = 8;
  localparam int unsigned TOG_W   = 9;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MODE  = 2'd1,
    OP_FLASH = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'd0,
    MODE_ON    = 3'd1,
    MODE_BLINK = 3'd2,
    MODE_FAST  = 3'd3,
    MODE_PULSE = 3'd4
  } mode_t;

  typedef enum logic {
    CFG_BLINK_INTERVAL = 1'b0,
    CFG_FAST_INTERVAL  = 1'b1
  } cfg_reg_t;

  localparam logic [DUR_W-1:0]  PULSE_STEP_MS     = 16'd50;
  localparam logic [RAMP_W-1:0] PULSE_STEP        = 8'd5;
  localparam logic [RAMP_W-1:0] PULSE_TOP         = 8'd255;
  localparam logic [RAMP_W-1:0] PULSE_THRESHOLD   = 8'd127;
  localparam logic [DUR_W-1:0]  FLASH_PHASE_RESET = 16'd200;
  localparam logic [DUR_W-1:0]  BLINK_RESET       = 16'd500;
  localparam logic [DUR_W-1:0]  FAST_BLINK_RESET  = 16'd100;
  localparam logic [DUR_W-1:0]  SAT_MAX           = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         operation;
    logic [2:0]         mode;
    logic [COUNT_W-1:0] flash_count;
    logic [DUR_W-1:0]   flash_duration_ms;
  } item_t;

  typedef struct packed {
    logic              led_level;
    logic              flash_busy;
    logic [2:0]        current_mode;
    logic [RAMP_W-1:0] pulse_level;
  } result_t;

  typedef struct packed {
    logic [DUR_W-1:0] blink_interval_ms;
    logic [DUR_W-1:0] fast_blink_interval_ms;
  } cfg_t;

  function automatic logic [DUR_W-1:0] sat_inc(input logic [DUR_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? SAT_MAX : v + 1'b1;
  endfunction

endpackage

>>> design/lms_channels.sv
// lms_channels: valid/ready channel interfaces for request, result and config
// depends on lms_pkg for field widths
interface lms_in_if;
  import lms_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [2:0]         mode;
  logic [COUNT_W-1:0] flash_count;
  logic [DUR_W-1:0]   flash_duration_ms;

  modport source (output valid, operation, mode, flash_count, flash_duration_ms,
                  input ready);
  modport sink   (input valid, operation, mode, flash_count, flash_duration_ms,
                  output ready);
endinterface

interface lms_out_if;
  import lms_pkg::*;
  logic              valid;
  logic              ready;
  logic              led_level;
  logic              flash_busy;
  logic [2:0]        current_mode;
  logic [RAMP_W-1:0] pulse_level;

  modport source (output valid, led_level, flash_busy, current_mode, pulse_level,
                  input ready);
  modport sink   (input valid, led_level, flash_busy, current_mode, pulse_level,
                  output ready);
endinterface

interface lms_cfg_if;
  import lms_pkg::*;
  logic             valid;
  logic             ready;
  logic             index;
  logic [DUR_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/lms_cfg_regs.sv
// lms_cfg_regs: blink interval configuration registers
// depends on lms_pkg
module lms_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic                    wr_index,
  input  logic [15:0]             wr_data,
  output lms_pkg::cfg_t           cfg
);
  import lms_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        CFG_BLINK_INTERVAL: cfg_nxt.blink_interval_ms      = wr_data;
        CFG_FAST_INTERVAL:  cfg_nxt.fast_blink_interval_ms = wr_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_interval_ms      <= BLINK_RESET;
      cfg_r.fast_blink_interval_ms <= FAST_BLINK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/lms_state_core.sv
// lms_state_core: led state registers and their single-pass update per request
// depends on lms_pkg
module lms_state_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  lms_pkg::item_t   item,
  input  lms_pkg::cfg_t    cfg,
  output lms_pkg::result_t result
);
  import lms_pkg::*;

  typedef struct packed {
    logic [2:0]        mode_reg;
    logic              lit_flag;
    logic              pin_level;
    logic [DUR_W-1:0]  since_update;
    logic              flashing;
    logic [TOG_W-1:0]  toggles_left;
    logic [DUR_W-1:0]  phase_length;
    logic [DUR_W-1:0]  phase_elapsed;
    logic [RAMP_W-1:0] ramp_value;
    logic              ramp_rising;
  } led_state_t;

  led_state_t st_r;
  led_state_t st_nxt;

  always_comb begin
    logic [DUR_W-1:0] interval;
    st_nxt   = st_r;
    interval = cfg.blink_interval_ms;
    case (op_t'(item.operation))
      OP_TICK: begin
        st_nxt.since_update = sat_inc(st_r.since_update);
        if (st_r.flashing) begin
          st_nxt.phase_elapsed = sat_inc(st_r.phase_elapsed);
          if (st_nxt.phase_elapsed >= st_r.phase_length) begin
            if (st_r.toggles_left != '0) begin
              st_nxt.toggles_left  = st_r.toggles_left - 1'b1;
              st_nxt.lit_flag      = ~st_r.lit_flag;
              st_nxt.pin_level     = ~st_r.lit_flag;
              st_nxt.phase_elapsed = '0;
            end else begin
              st_nxt.mode_reg     = MODE_OFF;
              st_nxt.since_update = '0;
              st_nxt.pin_level    = 1'b0;
              st_nxt.lit_flag     = 1'b0;
              st_nxt.flashing     = 1'b0;
            end
          end
        end else begin
          case (mode_t'(st_r.mode_reg))
            MODE_BLINK, MODE_FAST: begin
              if (mode_t'(st_r.mode_reg) == MODE_FAST) begin
                interval = cfg.fast_blink_interval_ms;
              end
              if (st_nxt.since_update >= interval) begin
                st_nxt.lit_flag     = ~st_r.lit_flag;
                st_nxt.pin_level    = ~st_r.lit_flag;
                st_nxt.since_update = '0;
              end
            end
            MODE_PULSE: begin
              if (st_nxt.since_update >= PULSE_STEP_MS) begin
                if (st_r.ramp_rising) begin
                  if (st_r.ramp_value >= PULSE_TOP - PULSE_STEP) begin
                    st_nxt.ramp_value  = PULSE_TOP;
                    st_nxt.ramp_rising = 1'b0;
                  end else begin
                    st_nxt.ramp_value = st_r.ramp_value + PULSE_STEP;
                  end
                end else begin
                  if (st_r.ramp_value <= PULSE_STEP) begin
                    st_nxt.ramp_value  = '0;
                    st_nxt.ramp_rising = 1'b1;
                  end else begin
                    st_nxt.ramp_value = st_r.ramp_value - PULSE_STEP;
                  end
                end
                st_nxt.pin_level    = (st_nxt.ramp_value > PULSE_THRESHOLD);
                st_nxt.since_update = '0;
              end
            end
            default: begin
              st_nxt.since_update = sat_inc(st_r.since_update);
            end
          endcase
        end
      end
      OP_MODE: begin
        if (item.mode inside {[MODE_OFF:MODE_PULSE]}) begin
          st_nxt.mode_reg     = item.mode;
          st_nxt.since_update = '0;
          if (mode_t'(item.mode) == MODE_OFF) begin
            st_nxt.pin_level = 1'b0;
            st_nxt.lit_flag  = 1'b0;
            st_nxt.flashing  = 1'b0;
          end else if (mode_t'(item.mode) == MODE_ON) begin
            st_nxt.pin_level = 1'b1;
            st_nxt.lit_flag  = 1'b1;
            st_nxt.flashing  = 1'b0;
          end
        end
      end
      OP_FLASH: begin
        st_nxt.toggles_left  = {item.flash_count, 1'b0};
        st_nxt.phase_length  = item.flash_duration_ms;
        st_nxt.phase_elapsed = '0;
        st_nxt.flashing      = 1'b1;
        st_nxt.lit_flag      = 1'b1;
        st_nxt.pin_level     = 1'b1;
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode_reg      <= MODE_OFF;
      st_r.lit_flag      <= 1'b0;
      st_r.pin_level     <= 1'b0;
      st_r.since_update  <= '0;
      st_r.flashing      <= 1'b0;
      st_r.toggles_left  <= '0;
      st_r.phase_length  <= FLASH_PHASE_RESET;
      st_r.phase_elapsed <= '0;
      st_r.ramp_value    <= '0;
      st_r.ramp_rising   <= 1'b1;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  assign result.led_level    = st_nxt.pin_level;
  assign result.flash_busy   = st_nxt.flashing;
  assign result.current_mode = st_nxt.mode_reg;
  assign result.pulse_level  = st_nxt.ramp_value;

endmodule

>>> design/led_mode_sequencer.sv
// led_mode_sequencer: single led driver with modes, pulse ramp and flash patterns
// depends on lms_pkg, lms_channels, lms_cfg_regs and lms_state_core
//
// One request per clock cycle, sustained while the result side is ready: a
// request is captured in the input register, passes the combinational update
// logic of the state core and its result lands in the output register. A
// result-side stall holds both registers. Operation 0 is a one-millisecond
// tick, 1 sets the mode (off, on, blink, fast blink, pulse; codes 5 to 7 do
// nothing), 2 starts a flash of flash_count*2 toggles of flash_duration_ms each,
// beginning lit. Every request gives exactly one result. Interval registers
// should only be written while no request is in flight.
module led_mode_sequencer (
  input logic        clk,
  input logic        rst_n,
  lms_in_if.sink     in_ch,
  lms_out_if.source  out_ch,
  lms_cfg_if.sink    cfg_ch
);
  import lms_pkg::*;

  item_t   in_item_r;
  logic    in_valid_r;
  result_t res_r;
  logic    out_valid_r;
  result_t res_nxt;
  cfg_t    cfg;
  logic    advance;
  logic    in_take;

  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  lms_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  lms_state_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.operation         <= in_ch.operation;
      in_item_r.mode              <= in_ch.mode;
      in_item_r.flash_count       <= in_ch.flash_count;
      in_item_r.flash_duration_ms <= in_ch.flash_duration_ms;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.led_level    = res_r.led_level;
  assign out_ch.flash_busy   = res_r.flash_busy;
  assign out_ch.current_mode = res_r.current_mode;
  assign out_ch.pulse_level  = res_r.pulse_level;

endmodule
